FILE: design/descending_value_sorter_unit_defines.svh
// Assertion macros shared by the sorter's checking code
`ifndef DESCENDING_VALUE_SORTER_UNIT_DEFINES_SVH
`define DESCENDING_VALUE_SORTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define DVS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorter check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define DVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorter check failed");

`endif

FILE: design/dvs_pkg.sv
// Types and constants of the descending value sorter
package dvs_pkg;

  localparam int DVS_VALUE_W      = 32;
  localparam int DVS_MAX_ELEMENTS = 16;

  typedef struct packed {
    logic signed [DVS_VALUE_W-1:0] value;
    logic                          last;
  } dvs_in_t;

  typedef struct packed {
    logic signed [DVS_VALUE_W-1:0] value_res;
    logic                          last_res;
  } dvs_out_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } dvs_state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } dvs_op_t;

  // Control broadcast along the cell chain
  typedef struct packed {
    dvs_op_t op;
  } dvs_cell_ctl_t;

endpackage

FILE: design/descending_value_sorter_unit.sv
// Descending value sorter: a set of signed values comes in one request per cycle
// while busy is low; the request with last set closes the set. Each request is
// placed at once into a chain of MAX_ELEMENTS cells kept in descending order. After
// the closing request busy rises and the chain shifts its contents out of the first
// cell, one result per cycle with out_strobe high, largest first, equal values in
// arrival order, last_res on the smallest, one result for each value kept. Results
// cannot be held off and must be taken in the cycle they appear. Values beyond
// MAX_ELEMENTS in a set are dropped; the set still closes on its last request.
`include "descending_value_sorter_unit_defines.svh"

module descending_value_sorter_unit
  import dvs_pkg::*;
#(
  parameter int MAX_ELEMENTS = DVS_MAX_ELEMENTS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dvs_in_t  in_data,
  output logic     out_strobe,
  output dvs_out_t out_res
);

  dvs_cell_ctl_t                 ctl;
  logic                          out_last;
  logic signed [DVS_VALUE_W-1:0] cell_val [MAX_ELEMENTS];
  logic                          cell_vld [MAX_ELEMENTS];
  logic                          cell_ge  [MAX_ELEMENTS];

  // Sequence loading and draining
  dvs_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_last    (in_data.last),
    .busy       (busy),
    .ctl        (ctl),
    .out_strobe (out_strobe),
    .out_last   (out_last)
  );

  // Build the chain of cells
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic                          p_ge;
    logic signed [DVS_VALUE_W-1:0] p_val;
    logic                          p_vld;
    logic signed [DVS_VALUE_W-1:0] n_val;
    logic                          n_vld;

    if (i == 0) begin : g_head
      assign p_ge  = 1'b1;
      assign p_val = in_data.value;
      assign p_vld = 1'b0;
    end else begin : g_body
      assign p_ge  = cell_ge[i-1];
      assign p_val = cell_val[i-1];
      assign p_vld = cell_vld[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign n_val = in_data.value;
      assign n_vld = 1'b0;
    end else begin : g_link
      assign n_val = cell_val[i+1];
      assign n_vld = cell_vld[i+1];
    end

    dvs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .ins_val  (in_data.value),
      .prev_ge  (p_ge),
      .prev_val (p_val),
      .prev_vld (p_vld),
      .next_val (n_val),
      .next_vld (n_vld),
      .val      (cell_val[i]),
      .vld      (cell_vld[i]),
      .ge       (cell_ge[i])
    );
  end

  // Drive the result from the head of the chain
  assign out_res.value_res = cell_val[0];
  assign out_res.last_res  = out_last;

  // Checks
  `DVS_ASSERT_NEXT(a_close_drains, start && !busy && in_data.last, out_strobe)
  `DVS_ASSERT_NEXT(a_drain_runs_on, out_strobe && !out_res.last_res, out_strobe)
  `DVS_ASSERT_NEXT(a_drain_ends, out_strobe && out_res.last_res, !busy)
  `DVS_ASSERT_IMPL(a_head_valid, out_strobe, cell_vld[0])
  `DVS_ASSERT_IMPL(a_order, out_strobe && !out_res.last_res, cell_val[0] >= cell_val[1])

endmodule

FILE: design/dvs_cell.sv
// One cell of the sorting chain: holds a value and its valid bit
module dvs_cell
  import dvs_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  dvs_cell_ctl_t                 ctl,
  input  logic signed [DVS_VALUE_W-1:0] ins_val,
  input  logic                          prev_ge,
  input  logic signed [DVS_VALUE_W-1:0] prev_val,
  input  logic                          prev_vld,
  input  logic signed [DVS_VALUE_W-1:0] next_val,
  input  logic                          next_vld,
  output logic signed [DVS_VALUE_W-1:0] val,
  output logic                          vld,
  output logic                          ge
);

  logic signed [DVS_VALUE_W-1:0] val_r, val_nxt;
  logic                          vld_r, vld_nxt;

  // Keep this entry if it ranks ahead of the request; equals stay ahead
  assign ge = vld_r && (val_r >= ins_val);

  // Choose the next content: keep, take the request, or take a neighbour
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    case (ctl.op)
      OP_INSERT: begin
        if (!ge) begin
          if (prev_ge) begin
            val_nxt = ins_val;
            vld_nxt = 1'b1;
          end else begin
            val_nxt = prev_val;
            vld_nxt = prev_vld;
          end
        end
      end
      OP_SHIFT: begin
        val_nxt = next_val;
        vld_nxt = next_vld;
      end
      default: begin
        val_nxt = val_r;
        vld_nxt = vld_r;
      end
    endcase
  end

  // Hold the value without reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  // Clear the valid bit on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

FILE: design/dvs_ctrl.sv
// Load and drain sequencing with the element count
module dvs_ctrl
  import dvs_pkg::*;
#(
  parameter int MAX_ELEMENTS = DVS_MAX_ELEMENTS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_last,
  output logic          busy,
  output dvs_cell_ctl_t ctl,
  output logic          out_strobe,
  output logic          out_last
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  dvs_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept;
  logic             full;

  assign accept = start && (state_r == ST_LOAD);
  assign full   = (count_r == CNT_W'(MAX_ELEMENTS));

  // Next state and count
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (!full) begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        count_nxt = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        count_nxt = '0;
      end
    endcase
  end

  // Outputs to the chain and the result port
  always_comb begin
    ctl.op     = OP_HOLD;
    busy       = 1'b0;
    out_strobe = 1'b0;
    out_last   = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (accept && !full) begin
          ctl.op = OP_INSERT;
        end
      end
      ST_DRAIN: begin
        ctl.op     = OP_SHIFT;
        busy       = 1'b1;
        out_strobe = 1'b1;
        out_last   = (count_r == CNT_W'(1));
      end
      default: begin
        ctl.op = OP_HOLD;
      end
    endcase
  end

  // Advance state and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
